// ----- rtl/can_tx_queue_with_mailbox_bypass_defines.svh -----
// Assertion macros for the CAN transmit queue.
// Included by the top level; depends on nothing else.
`ifndef CAN_TX_QUEUE_WITH_MAILBOX_BYPASS_DEFINES_SVH
`define CAN_TX_QUEUE_WITH_MAILBOX_BYPASS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CTQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cantxq_pkg.sv -----
// Shared types and constants of the CAN transmit queue.
// Used by the controller, the datapath and the top level.
package cantxq_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int ID_W            = 29;
  localparam int STD_ID_W        = 11;
  localparam int LEN_W           = 4;
  localparam int NUM_BYTES       = 8;
  localparam int BYTES_W         = 64;
  localparam int CNT_OUT_W       = 9;

  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_DONE = 1'b1;

  typedef struct packed {
    logic               action;
    logic               frame_ext;
    logic               frame_is_data;
    logic [ID_W-1:0]    frame_id;
    logic [LEN_W-1:0]   frame_len;
    logic [BYTES_W-1:0] frame_bytes;
  } req_t;

  typedef struct packed {
    logic                 status;
    logic                 load_valid;
    logic                 load_ext;
    logic                 load_rtr;
    logic [ID_W-1:0]      load_id;
    logic [LEN_W-1:0]     load_len;
    logic [BYTES_W-1:0]   load_bytes;
    logic [CNT_OUT_W-1:0] queued_count;
    logic                 can_accept;
  } res_t;

  // one queue entry: control bits, length, identifier, data bytes
  typedef struct packed {
    logic               ext;
    logic               is_data;
    logic [LEN_W-1:0]   len;
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_REFUSE,
    OP_LOAD,
    OP_ENQ,
    OP_POP,
    OP_FREE
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic rd_en;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic empty;
    logic full;
    logic mb_busy;
  } stat_t;

endpackage

// ----- rtl/cantxq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package needed.
module cantxq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cantxq_ctrl.sv -----
// Controller FSM of the CAN transmit queue: sequences capture and response.
// Depends on cantxq_pkg.
module cantxq_ctrl
  import cantxq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output logic  busy_o,
  output logic  res_valid_o,
  output cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '{capture: 1'b0, rd_en: 1'b0, op: OP_NONE};
    busy_o      = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = start_i;
        cmd_o.rd_en   = start_i;
      end
      ST_RESP: begin
        busy_o      = 1'b1;
        res_valid_o = 1'b1;
        if (stat_i.action == ACT_SEND) begin
          if (stat_i.full) begin
            cmd_o.op = OP_REFUSE;
          end else if (stat_i.empty && !stat_i.mb_busy) begin
            cmd_o.op = OP_LOAD;
          end else begin
            cmd_o.op = OP_ENQ;
          end
        end else begin
          cmd_o.op = stat_i.empty ? OP_FREE : OP_POP;
        end
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/cantxq_dp.sv -----
// Datapath of the CAN transmit queue: pointers, count, mailbox flag, frame RAM.
// Depends on cantxq_pkg and cantxq_ram.
module cantxq_dp
  import cantxq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output res_t  res_o
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(QUEUE_DEPTH - 1);

  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [ADDR_W-1:0] tail_q, tail_d;
  logic              mb_busy_q, mb_busy_d;
  logic              action_q;
  entry_t            frame_q, frame_d;
  logic [ENTRY_W-1:0] rd_data;
  entry_t            load_src;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

  // normalize the incoming frame: short id, bytes past length zeroed
  always_comb begin
    frame_d.ext     = req_i.frame_ext;
    frame_d.is_data = req_i.frame_is_data;
    frame_d.len     = req_i.frame_len;
    frame_d.id      = req_i.frame_ext ? req_i.frame_id :
                      {{(ID_W-STD_ID_W){1'b0}}, req_i.frame_id[STD_ID_W-1:0]};
    for (int i = 0; i < NUM_BYTES; i++) begin
      frame_d.bytes[8*i +: 8] = (req_i.frame_len > LEN_W'(i)) ?
                                req_i.frame_bytes[8*i +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      frame_q  <= frame_d;
      action_q <= req_i.action;
    end
  end

  cantxq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_ENQ),
    .waddr_i (tail_q),
    .wdata_i (frame_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (head_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    count_d   = count_q;
    head_d    = head_q;
    tail_d    = tail_q;
    mb_busy_d = mb_busy_q;
    case (cmd_i.op)
      OP_LOAD: begin
        mb_busy_d = 1'b1;
      end
      OP_ENQ: begin
        count_d = count_q + CNT_W'(1);
        tail_d  = (tail_q == LAST_A) ? '0 : tail_q + ADDR_W'(1);
      end
      OP_POP: begin
        count_d   = count_q - CNT_W'(1);
        head_d    = (head_q == LAST_A) ? '0 : head_q + ADDR_W'(1);
        mb_busy_d = 1'b1;
      end
      OP_FREE: begin
        mb_busy_d = 1'b0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      mb_busy_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      mb_busy_q <= mb_busy_d;
    end
  end

  assign stat_o.action  = action_q;
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.full    = (count_q >= DEPTH_C);
  assign stat_o.mb_busy = mb_busy_q;

  assign cnt_wide = {{CNT_OUT_W{1'b0}}, count_d};

  always_comb begin
    load_src = (cmd_i.op == OP_POP) ? entry_t'(rd_data) : frame_q;
    res_o    = '0;
    res_o.status       = (cmd_i.op == OP_REFUSE);
    res_o.queued_count = cnt_wide[CNT_OUT_W-1:0];
    res_o.can_accept   = (count_d < DEPTH_C);
    if (cmd_i.op == OP_LOAD || cmd_i.op == OP_POP) begin
      res_o.load_valid = 1'b1;
      res_o.load_ext   = load_src.ext;
      res_o.load_rtr   = !load_src.is_data;
      res_o.load_id    = load_src.id;
      res_o.load_len   = load_src.len;
      res_o.load_bytes = load_src.bytes;
    end
  end

endmodule

// ----- rtl/can_tx_queue_with_mailbox_bypass.sv -----
// Top level of the CAN transmit queue with mailbox bypass.
// Depends on cantxq_pkg, cantxq_ctrl, cantxq_dp and the defines header.
//
// Usage:
//  - Request channel: drive req_i and raise start_i; the request is taken at
//    a rising edge with start_i high and busy_o low. action 0 is a send
//    request carrying a frame, action 1 is a transmit-done event.
//  - Result channel: res_o is valid for exactly one cycle while res_valid_o
//    is high; the receiver cannot stall, so it must sample it then.
//  - Latency: the result appears in the cycle after the request is taken.
//  - Pacing: no new request is taken while busy_o is high, as it is in the
//    result cycle; the frame RAM has a registered read, so a pop reads the
//    head entry in the capture cycle and answers in the next.
//  - A send is refused (status 1) when QUEUE_DEPTH frames wait. With the
//    queue empty and the mailbox idle it is loaded at once, else queued.
//  - A done event frees the mailbox and loads the oldest waiting frame, if any.
//  - Reset: empty queue, mailbox idle, no request in flight. The frame RAM
//    is not cleared; entries are read only after being written.
`include "can_tx_queue_with_mailbox_bypass_defines.svh"

module can_tx_queue_with_mailbox_bypass
  import cantxq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  cmd_t  cmd;
  stat_t stat;

  cantxq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .stat_i      (stat),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .cmd_o       (cmd)
  );

  cantxq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

  `CTQ_ASSERT_NXT(a_resp_next, clk_i, rst_ni, start_i && !busy_o, res_valid_o, "no result after request")
  `CTQ_ASSERT_NXT(a_idle_after, clk_i, rst_ni, res_valid_o, !busy_o, "busy held after result")
  `CTQ_ASSERT_IMP(a_refuse_full, clk_i, rst_ni, res_valid_o && res_o.status, !res_o.load_valid && !res_o.can_accept, "refused request loaded or not full")
  `CTQ_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, cmd.op == OP_POP, !stat.empty && stat.action == ACT_DONE, "pop from empty queue")

endmodule

// ----- sim/tb_can_tx_queue_with_mailbox_bypass.sv -----
// Testbench for the CAN transmit queue with mailbox bypass: directed frames, then random
// send/done traffic with random gaps, including a fill to full, refusals and a full drain.
// Depends on cantxq_pkg and can_tx_queue_with_mailbox_bypass.
module tb_can_tx_queue_with_mailbox_bypass;
  import cantxq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;

  class tx_queue_mirror;
    entry_t      frames [DEPTH];
    int unsigned waiting;
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    bit          mbox_busy;
    res_t        due_results [$];
    int          errors;

    function logic [63:0] trim_bytes(logic [63:0] b, logic [3:0] len);
      if (len >= 4'd8) return b;
      return b & ((64'd1 << (8 * len)) - 64'd1);
    endfunction

    function res_t loaded(entry_t f);
      res_t r;
      r = '0;
      r.load_valid = 1'b1;
      r.load_ext   = f.ext;
      r.load_rtr   = !f.is_data;
      r.load_id    = f.id;
      r.load_len   = f.len;
      r.load_bytes = f.bytes;
      return r;
    endfunction

    function void note_request(req_t q);
      res_t   e;
      entry_t f;
      e = '0;
      if (q.action == ACT_SEND) begin
        if (waiting >= DEPTH) begin
          e.status = 1'b1;
        end else begin
          f.ext     = q.frame_ext;
          f.is_data = q.frame_is_data;
          f.len     = q.frame_len;
          f.id      = q.frame_ext ? q.frame_id : {18'd0, q.frame_id[10:0]};
          f.bytes   = trim_bytes(q.frame_bytes, q.frame_len);
          if (waiting == 0 && !mbox_busy) begin
            mbox_busy = 1'b1;
            e = loaded(f);
          end else begin
            frames[wr_ptr] = f;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            waiting++;
          end
        end
      end else begin
        mbox_busy = 1'b0;
        if (waiting > 0) begin
          e = loaded(frames[rd_ptr]);
          rd_ptr = (rd_ptr + 1) % DEPTH;
          waiting--;
          mbox_busy = 1'b1;
        end
      end
      e.queued_count = 9'(waiting);
      e.can_accept   = (waiting < DEPTH);
      due_results.push_back(e);
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: %0h", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      cmp("status", want.status, got.status);
      cmp("load_valid", want.load_valid, got.load_valid);
      cmp("load_ext", want.load_ext, got.load_ext);
      cmp("load_rtr", want.load_rtr, got.load_rtr);
      cmp("load_id", want.load_id, got.load_id);
      cmp("load_len", want.load_len, got.load_len);
      cmp("load_bytes", want.load_bytes, got.load_bytes);
      cmp("queued_count", want.queued_count, got.queued_count);
      cmp("can_accept", want.can_accept, got.can_accept);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  tx_queue_mirror mirror;
  bit             steady;

  can_tx_queue_with_mailbox_bypass #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) mirror.check_result(res_o);
  end

  function automatic req_t frame(bit ext, bit dat, logic [28:0] id, logic [3:0] len,
                                 logic [63:0] b);
    req_t r;
    r.action        = ACT_SEND;
    r.frame_ext     = ext;
    r.frame_is_data = dat;
    r.frame_id      = id;
    r.frame_len     = len;
    r.frame_bytes   = b;
    return r;
  endfunction

  function automatic req_t rand_send();
    logic [3:0] len;
    len = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
    return frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 29'($urandom), len,
                 {$urandom, $urandom});
  endfunction

  function automatic req_t rand_done();
    req_t r;
    r = rand_send();
    r.action = ACT_DONE;
    return r;
  endfunction

  function automatic req_t done_req();
    req_t r;
    r = '0;
    r.action = ACT_DONE;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic issue(req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    mirror.note_request(r);
  endtask

  task automatic issue_gapped(req_t r);
    int n;
    n = gap_len();
    issue(r);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic mixed_run(int n, int send_pct);
    repeat (n) issue_gapped(($urandom_range(0, 99) < send_pct) ? rand_send() : rand_done());
  endtask

  task automatic fill_and_drain();
    while (mirror.waiting < DEPTH)
      issue_gapped(($urandom_range(0, 99) < 97) ? rand_send() : rand_done());
    repeat (4) issue_gapped(rand_send());
    issue_gapped(rand_done());
    issue_gapped(rand_send());
    issue_gapped(rand_send());
    while (mirror.waiting > 0)
      issue_gapped(($urandom_range(0, 99) < 3) ? rand_send() : rand_done());
    repeat (2) issue_gapped(rand_done());
  endtask

  initial begin
    mirror  = new();
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: spurious done, bypass, id cut, long lengths, remote frames, pops
    issue_gapped(done_req());
    issue_gapped(frame(1'b0, 1'b1, 29'h1FFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    issue_gapped(frame(1'b1, 1'b1, 29'h1FFF_FFFF, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    issue_gapped(frame(1'b0, 1'b0, 29'h0ABC_DEF1, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF));
    issue_gapped(frame(1'b1, 1'b1, 29'h0, 4'd9, 64'h0123_4567_89AB_CDEF));
    issue_gapped(frame(1'b1, 1'b0, 29'h1555_5555, 4'd15, 64'hA5A5_5A5A_F00F_0FF0));
    issue_gapped(frame(1'b0, 1'b1, 29'h0AAA_AAAA, 4'd1, 64'hFEDC_BA98_7654_3210));
    repeat (6) issue_gapped(rand_done());
    issue_gapped(done_req());
    issue_gapped(frame(1'b0, 1'b1, 29'h0, 4'd0, 64'h0));
    issue_gapped(frame(1'b1, 1'b0, 29'h1, 4'd8, 64'h8000_0000_0000_0001));
    issue_gapped(frame(1'b0, 1'b1, 29'h7FF, 4'd7, 64'hFFFF_FFFF_FFFF_FFFF));
    repeat (3) issue_gapped(rand_done());
    drain();

    mixed_run(15, 55);
    drain();
    steady = 1'b1;
    mixed_run(10, 50);
    drain();
    steady = 1'b0;
    fill_and_drain();
    drain();
    mixed_run(10, 62);
    steady = 1'b1;
    mixed_run(5, 50);

    drain();
    repeat (5) @(posedge clk_i);
    if (mirror.due_results.size() != 0)
      $error("%0d results never arrived", mirror.due_results.size());
    if (mirror.errors == 0 && mirror.due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
